@@ rtl/fru_pkg.sv @@
package fru_pkg;

  // gcd steps per operand bit; each step drops at least one bit of a or b
  localparam int unsigned GCD_STEPS_PER_BIT = 2;

  // final stage that puts signs back on the quotients
  localparam int unsigned SIGN_STAGES = 1;

endpackage

@@ rtl/fru_ifs.sv @@
interface fru_req_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] numerator_in;
  logic signed [W-1:0] denominator_in;

  modport source (output valid, numerator_in, denominator_in, input ready);
  modport sink   (input valid, numerator_in, denominator_in, output ready);
endinterface

interface fru_rsp_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] numerator_out;
  logic signed [W-1:0] denominator_out;
  logic                zero_denominator;

  modport source (output valid, numerator_out, denominator_out, zero_denominator,
                  input ready);
  modport sink   (input valid, numerator_out, denominator_out, zero_denominator,
                  output ready);
endinterface

@@ rtl/fraction_reducer_unit.sv @@
// channel | dir | word
// req     | in  | numerator_in, denominator_in
// rsp     | out | numerator_out, denominator_out, zero_denominator
//
// One word per cycle in and out, unless a stall on rsp holds the pipe.
// Stages: 1 prep, 2*DATA_WIDTH binary gcd steps, DATA_WIDTH divider bits
// (both quotients in parallel), 1 sign stage.
// rst clears all stage valid bits.
// A stall on rsp with the last stage full freezes the whole pipe.
module fraction_reducer_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  fru_req_if.sink   req,
  fru_rsp_if.source rsp
);

  localparam int W      = DATA_WIDTH;
  localparam int NGCD   = fru_pkg::GCD_STEPS_PER_BIT * W;
  localparam int DIV0   = 1 + NGCD;
  localparam int SGN    = DIV0 + W;
  localparam int S      = SGN + fru_pkg::SIGN_STAGES;

  typedef struct packed {
    logic         pass;
    logic         zd;
    logic         nneg;
    logic         dneg;
    logic [W-1:0] nin;
    logic [W-1:0] din;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] nn;
    logic [W-1:0] dd;
    logic [W-1:0] nrem;
    logic [W-1:0] drem;
    logic [W-1:0] nq;
    logic [W-1:0] dq;
  } st_t;

  st_t          st     [S];
  st_t          st_next[S];
  logic [S-1:0] vld;
  logic         adv;
  logic         acc_in;

  assign adv       = !vld[S-1] || rsp.ready;
  assign req.ready = adv;
  assign acc_in    = req.valid && adv;

  function automatic st_t prep(logic [W-1:0] num, logic [W-1:0] den);
    st_t          s;
    logic [W-1:0] na;
    logic [W-1:0] da;
    logic [W-1:0] orv;
    logic [W-1:0] a0;
    logic [W-1:0] b0;
    int           k;
    s      = '0;
    s.nin  = num;
    s.din  = den;
    s.zd   = (den == '0);
    s.pass = (num == '0) || (den == '0);
    s.nneg = num[W-1];
    s.dneg = den[W-1];
    na     = num[W-1] ? (~num + 1'b1) : num;
    da     = den[W-1] ? (~den + 1'b1) : den;
    if (s.pass) begin
      na = W'(1);
      da = W'(1);
    end
    orv = na | da;
    k   = 0;
    for (int i = W - 1; i >= 0; i--) begin
      if (orv[i]) k = i;
    end
    a0   = na >> k;
    b0   = da >> k;
    s.nn = a0;
    s.dd = b0;
    if (!a0[0]) begin
      s.a = b0;
      s.b = a0;
    end else begin
      s.a = a0;
      s.b = b0;
    end
    return s;
  endfunction

  // a stays odd; b drops a factor of two or takes |a-b|/2
  function automatic st_t gstep(st_t s);
    st_t          r;
    logic [W-1:0] diff;
    r    = s;
    diff = (s.a > s.b) ? (s.a - s.b) : (s.b - s.a);
    if (s.b != '0) begin
      if (!s.b[0]) begin
        r.b = s.b >> 1;
      end else begin
        if (s.a > s.b) r.a = s.b;
        r.b = diff >> 1;
      end
    end
    return r;
  endfunction

  function automatic st_t dstep(st_t s, int j);
    st_t        r;
    logic [W:0] tn;
    logic [W:0] td;
    r  = s;
    tn = {s.nrem, s.nn[W-1-j]};
    td = {s.drem, s.dd[W-1-j]};
    if (tn >= {1'b0, s.a}) begin
      tn            = tn - {1'b0, s.a};
      r.nq[W-1-j]   = 1'b1;
    end
    if (td >= {1'b0, s.a}) begin
      td            = td - {1'b0, s.a};
      r.dq[W-1-j]   = 1'b1;
    end
    r.nrem = tn[W-1:0];
    r.drem = td[W-1:0];
    return r;
  endfunction

  function automatic st_t sgn(st_t s);
    st_t r;
    r = s;
    if (!s.pass) begin
      r.nin = s.nneg ? (~s.nq + 1'b1) : s.nq;
      r.din = s.dneg ? (~s.dq + 1'b1) : s.dq;
    end
    return r;
  endfunction

  for (genvar i = 0; i < S; i++) begin : g_st
    if (i == 0) begin : g_prep
      always_comb begin
        st_next[i] = prep(req.numerator_in, req.denominator_in);
      end
      always_ff @(posedge clk) begin
        if (rst) vld[i] <= 1'b0;
        else if (adv) vld[i] <= acc_in;
      end
    end else begin : g_run
      if (i < DIV0) begin : g_gcd
        always_comb begin
          st_next[i] = gstep(st[i-1]);
        end
      end else if (i < SGN) begin : g_div
        always_comb begin
          st_next[i] = dstep(st[i-1], i - DIV0);
        end
      end else begin : g_sgn
        always_comb begin
          st_next[i] = sgn(st[i-1]);
        end
      end
      always_ff @(posedge clk) begin
        if (rst) vld[i] <= 1'b0;
        else if (adv) vld[i] <= vld[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) st[i] <= st_next[i];
    end
  end

  assign rsp.valid            = vld[S-1];
  assign rsp.numerator_out    = st[S-1].nin;
  assign rsp.denominator_out  = st[S-1].din;
  assign rsp.zero_denominator = st[S-1].zd;

  a_zd_den: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.zero_denominator |-> rsp.denominator_out == '0)
    else $error("zero flag with nonzero denominator");

  a_nz_den: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.zero_denominator |-> rsp.denominator_out != '0)
    else $error("reduced denominator is zero");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipe moved during stall");

  a_gcd_odd: assert property (@(posedge clk) disable iff (rst)
    vld[DIV0-1] |-> st[DIV0-1].a[0] && st[DIV0-1].b == '0)
    else $error("gcd not finished");

endmodule
